[design/od2bpp_pkg.sv]
// Shared types, constants and the Bayer table for the 2bpp ordered-dither packer.
package od2bpp_pkg;

    localparam int          SAMPLE_W          = 8;
    localparam int          IMAGE_WIDTH_W     = 13;
    localparam int          LEVEL_W           = 2;
    localparam int          PACK_W            = 6;
    localparam int          SLOT_W            = 2;
    localparam int          PHASE_W           = 3;
    localparam int          BAYER_W           = 6;

    localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd600;
    localparam logic [7:0]  GRAY_SCALE        = 8'd85;
    localparam logic [7:0]  LOW_CLIP          = 8'd5;
    localparam logic [7:0]  HIGH_CLIP         = 8'd250;
    localparam logic [5:0]  BAYER_BIAS        = 6'd33;
    localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 2'd3;
    localparam logic [SLOT_W-1:0]  SLOT_FULL   = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_sample;
        logic [SAMPLE_W-1:0] green_sample;
        logic [SAMPLE_W-1:0] blue_sample;
        logic                end_of_image;
    } pixel_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } result_t;

    typedef struct packed {
        logic [PHASE_W-1:0] col;
        logic [PHASE_W-1:0] row;
    } phase_t;

    localparam logic [BAYER_W-1:0] BAYER8 [64] = '{
        6'd0,  6'd32, 6'd12, 6'd44, 6'd2,  6'd34, 6'd14, 6'd46,
        6'd48, 6'd16, 6'd60, 6'd28, 6'd50, 6'd18, 6'd62, 6'd30,
        6'd8,  6'd40, 6'd4,  6'd36, 6'd10, 6'd42, 6'd6,  6'd38,
        6'd56, 6'd24, 6'd52, 6'd20, 6'd58, 6'd26, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd15, 6'd47, 6'd1,  6'd33, 6'd13, 6'd45,
        6'd51, 6'd19, 6'd63, 6'd31, 6'd49, 6'd17, 6'd61, 6'd29,
        6'd11, 6'd43, 6'd7,  6'd39, 6'd9,  6'd41, 6'd5,  6'd37,
        6'd59, 6'd27, 6'd55, 6'd23, 6'd57, 6'd25, 6'd53, 6'd21
    };

    function automatic logic [BAYER_W-1:0] bayer_entry(input phase_t ph);
        return BAYER8[{ph.row, ph.col}];
    endfunction

endpackage

[design/od2bpp_level.sv]
// Gray conversion and ordered-dither threshold: one pixel to one 2-bit level.
module od2bpp_level
    import od2bpp_pkg::*;
(
    input  pixel_t             pixel,
    input  phase_t             phase,
    output logic [LEVEL_W-1:0] level
);

    logic [9:0]        rgb_sum;
    logic [15:0]       gray_prod;
    logic [7:0]        gray;
    logic signed [9:0] dither_sum;

    assign rgb_sum   = 10'(pixel.red_sample) + 10'(pixel.green_sample)
                     + 10'(pixel.blue_sample);
    // 765 * 85 stays below 2^16
    assign gray_prod = 16'(rgb_sum * 16'(GRAY_SCALE));
    assign gray      = gray_prod[15:8];

    assign dither_sum = $signed({2'b00, gray})
                      + $signed({4'b0000, bayer_entry(phase)})
                      - $signed({4'b0000, BAYER_BIAS});

    always_comb begin
        if (gray < LOW_CLIP) begin
            level = LEVEL_BLACK;
        end else if (gray >= HIGH_CLIP) begin
            level = LEVEL_WHITE;
        end else if (dither_sum < $signed({2'b00, LOW_CLIP})) begin
            level = LEVEL_BLACK;
        end else if (dither_sum >= $signed({2'b00, HIGH_CLIP})) begin
            level = LEVEL_WHITE;
        end else begin
            level = dither_sum[7:6];
        end
    end

endmodule

[design/ordered_dither_2bpp_packer_unit.sv]
// Top level: 8x8 Bayer ordered dither to 2 bits per pixel, packed four pixels per byte.
//
//   channel   ports                        payload    direction
//   pixel     s_valid s_ready s_pixel      pixel_t    in
//   byte      m_valid m_ready m_result     result_t   out
//   config    cfg_wr_en cfg_wr_data        13 bits    in
//
// One pixel per clock while m_ready allows; a pixel goes through the pixel register,
// which holds the column and row phase taken at accept, and then the byte register;
// the level and pack logic between the two sets the rate.
// Synchronous active-low reset clears the phase counters, pack state and valids.
// A stalled byte holds the pipeline only once the pixel register is also full.
module ordered_dither_2bpp_packer_unit
    import od2bpp_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [IMAGE_WIDTH_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pixel_t                   s_pixel,
    output logic                     m_valid,
    input  logic                     m_ready,
    output result_t                  m_result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > IMAGE_WIDTH_W + 1) ? CW + 1 : IMAGE_WIDTH_W + 1;

    logic [IMAGE_WIDTH_W-1:0] image_width_reg;
    logic [CW-1:0]            col_count_reg, col_count_next;
    logic [PHASE_W-1:0]       row_phase_reg, row_phase_next;
    logic                     s1_valid_reg;
    pixel_t                   s1_pixel_reg;
    phase_t                   s1_phase_reg;
    logic [PACK_W-1:0]        pack_shift_reg, pack_shift_next;
    logic [SLOT_W-1:0]        slot_count_reg, slot_count_next;
    logic                     m_valid_reg;
    result_t                  m_result_reg, m_result_next;

    logic [EW-1:0]            eff_width;
    logic [EW-1:0]            col_plus_one;
    logic                     s_accept;
    logic                     out_free;
    logic                     s1_advance;
    logic                     emit;
    logic [LEVEL_W-1:0]       level;
    logic [7:0]               bits;

    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // zero width acts as one; saturate at the column counter's range
    always_comb begin
        if (image_width_reg == '0) begin
            eff_width = EW'(1);
        end else if (EW'(image_width_reg) > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = EW'(image_width_reg);
        end
    end

    assign col_plus_one = EW'(col_count_reg) + EW'(1);

    always_comb begin
        col_count_next = col_count_reg;
        row_phase_next = row_phase_reg;
        if (s_accept) begin
            if (s_pixel.end_of_image) begin
                col_count_next = '0;
                row_phase_next = '0;
            end else if (col_plus_one >= eff_width) begin
                col_count_next = '0;
                row_phase_next = row_phase_reg + PHASE_W'(1);
            end else begin
                col_count_next = col_plus_one[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMAGE_WIDTH_RESET;
            col_count_reg   <= '0;
            row_phase_reg   <= '0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                image_width_reg <= cfg_wr_data;
            end
            col_count_reg <= col_count_next;
            row_phase_reg <= row_phase_next;
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg     <= s_pixel;
            s1_phase_reg.col <= col_count_reg[PHASE_W-1:0];
            s1_phase_reg.row <= row_phase_reg;
        end
    end

    od2bpp_level u_level (
        .pixel (s1_pixel_reg),
        .phase (s1_phase_reg),
        .level (level)
    );

    assign bits = {pack_shift_reg, level};
    assign emit = s1_pixel_reg.end_of_image || (slot_count_reg == SLOT_FULL);

    always_comb begin
        pack_shift_next = pack_shift_reg;
        slot_count_next = slot_count_reg;
        m_result_next   = m_result_reg;
        if (s1_advance) begin
            if (emit) begin
                // left-align a partial byte, zero-filling the unused slots
                m_result_next.packed_byte = bits << {~slot_count_reg, 1'b0};
                m_result_next.last_byte   = s1_pixel_reg.end_of_image;
                pack_shift_next           = '0;
                slot_count_next           = '0;
            end else begin
                pack_shift_next = bits[PACK_W-1:0];
                slot_count_next = slot_count_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_shift_reg <= '0;
            slot_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pack_shift_reg <= pack_shift_next;
            slot_count_reg <= slot_count_next;
            if (s1_advance && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> EW'(col_count_reg) < $past(eff_width))
        else $error("column count not below effective width");

    a_eoi_clears_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && s1_pixel_reg.end_of_image
        |=> slot_count_reg == '0 && pack_shift_reg == '0 && m_valid_reg
            && m_result_reg.last_byte)
        else $error("end of image did not flush pack state");

    a_full_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && slot_count_reg == SLOT_FULL |=> m_valid_reg)
        else $error("full byte not emitted");

    a_byte_from_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !$past(m_valid_reg) |-> $past(s1_advance))
        else $error("byte appeared without a pixel advancing");

    a_pixel_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_pixel_reg))
        else $error("pending pixel dropped or changed");

endmodule
